>>> hw/rtl/adl_pkg.sv
// shared types, constants and helpers for the array doubly linked list
// no dependencies
`default_nettype none

package adl_pkg;

  localparam int SLOTS        = 8;
  localparam int PAYLOAD_BITS = 32;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int LINK_W       = 4;
  localparam int CMD_W        = 3;
  localparam int ANCHOR_W     = 3;
  localparam int STATUS_W     = 3;

  localparam logic [LINK_W-1:0] NONE_SLOT = LINK_W'(SLOTS);

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_AFTER = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ANCHOR_FREE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_NEXT     = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [ANCHOR_W-1:0]     anchor;
  } adl_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LINK_W-1:0]   slot;
    logic [LINK_W-1:0]   count;
    logic [LINK_W-1:0]   head_slot;
    logic [LINK_W-1:0]   tail_slot;
  } adl_out_t;

  typedef struct packed {
    logic [SLOT_W-1:0] raddr;
    logic              nx_we;
    logic [SLOT_W-1:0] nx_waddr;
    logic [LINK_W-1:0] nx_wdata;
    logic              pv_we;
    logic [SLOT_W-1:0] pv_waddr;
    logic [LINK_W-1:0] pv_wdata;
  } link_req_t;

  function automatic logic in_pool(input logic [LINK_W-1:0] s);
    return s < NONE_SLOT;
  endfunction

  function automatic logic [SLOT_W-1:0] lowest_free(input logic [SLOTS-1:0] m);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = SLOT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/adl_ram.sv
// generic single write, single read port ram with registered read data
// no dependencies
`default_nettype none

module adl_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 4,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/adl_ctrl.sv
// command sequencer: free mask, head, tail, count, payload store and link updates
// depends on adl_pkg; drives the link rams through link_req_t
`default_nettype none

module adl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire adl_pkg::adl_in_t   in_item,
  output logic                    busy,
  output logic                    out_valid,
  output adl_pkg::adl_out_t       out_item,
  output adl_pkg::link_req_t      link_req,
  input  wire logic [adl_pkg::LINK_W-1:0] nx_q,
  input  wire logic [adl_pkg::LINK_W-1:0] pv_q
);

  import adl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_LOOK2 = 2'd2;
  localparam logic [1:0] S_FIX = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [ANCHOR_W-1:0]     anc_r, anc_nxt;
  logic [SLOTS-1:0]        free_r, free_nxt;
  logic [LINK_W-1:0]       head_r, head_nxt;
  logic [LINK_W-1:0]       tail_r, tail_nxt;
  logic [LINK_W-1:0]       count_r, count_nxt;
  logic [LINK_W-1:0]       ns_r, ns_nxt;
  logic [LINK_W-1:0]       na_r, na_nxt;
  logic [LINK_W-1:0]       nn_r, nn_nxt;
  logic                    out_valid_r, out_valid_nxt;
  adl_out_t                out_r, out_nxt;

  logic [PAYLOAD_BITS-1:0] entry_mem [SLOTS];
  logic                    ent_we;
  logic [SLOT_W-1:0]       ent_addr;

  logic [LINK_W-1:0]       anc_link;
  logic                    anc_used;
  logic                    full;
  logic [SLOT_W-1:0]       new_slot;
  logic                    fin;
  logic [STATUS_W-1:0]     fin_status;
  logic [LINK_W-1:0]       fin_slot;
  logic                    do_unlink;
  logic [LINK_W-1:0]       uv, up, un;
  logic [LINK_W-1:0]       ins_a, ins_n;

  assign anc_link  = LINK_W'(anc_r);
  assign anc_used  = in_pool(anc_link) && !free_r[anc_r[SLOT_W-1:0]];
  assign full      = count_r >= NONE_SLOT;
  assign new_slot  = lowest_free(free_r);
  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    pay_nxt    = pay_r;
    anc_nxt    = anc_r;
    free_nxt   = free_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    ns_nxt     = ns_r;
    na_nxt     = na_r;
    nn_nxt     = nn_r;
    link_req   = '0;
    ent_we     = 1'b0;
    ent_addr   = new_slot;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_slot   = NONE_SLOT;
    do_unlink  = 1'b0;
    uv         = NONE_SLOT;
    up         = NONE_SLOT;
    un         = NONE_SLOT;
    ins_a      = NONE_SLOT;
    ins_n      = NONE_SLOT;

    case (state_r)
      S_IDLE: begin
        case (in_item.cmd)
          CMD_DEL_FRONT: link_req.raddr = head_r[SLOT_W-1:0];
          CMD_DEL_BACK:  link_req.raddr = tail_r[SLOT_W-1:0];
          default:       link_req.raddr = in_item.anchor[SLOT_W-1:0];
        endcase
        if (start) begin
          cmd_nxt   = in_item.cmd;
          pay_nxt   = in_item.payload;
          anc_nxt   = in_item.anchor;
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        case (cmd_r)
          CMD_INS_FRONT, CMD_INS_AFTER, CMD_INS_BACK: begin
            if (full) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else if (cmd_r == CMD_INS_AFTER && !anc_used) begin
              fin        = 1'b1;
              fin_status = ST_ANCHOR_FREE;
            end else begin
              case (cmd_r)
                CMD_INS_FRONT: begin
                  ins_a = NONE_SLOT;
                  ins_n = head_r;
                end
                CMD_INS_AFTER: begin
                  ins_a = anc_link;
                  ins_n = nx_q;
                end
                default: begin
                  ins_a = tail_r;
                  ins_n = NONE_SLOT;
                end
              endcase
              link_req.nx_we    = 1'b1;
              link_req.nx_waddr = new_slot;
              link_req.nx_wdata = ins_n;
              link_req.pv_we    = 1'b1;
              link_req.pv_waddr = new_slot;
              link_req.pv_wdata = ins_a;
              ent_we            = 1'b1;
              ns_nxt            = LINK_W'(new_slot);
              na_nxt            = ins_a;
              nn_nxt            = ins_n;
              state_nxt         = S_FIX;
            end
          end
          CMD_DEL_FRONT, CMD_DEL_BACK: begin
            uv = (cmd_r == CMD_DEL_FRONT) ? head_r : tail_r;
            if (!in_pool(uv)) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              do_unlink = 1'b1;
              up        = pv_q;
              un        = nx_q;
            end
          end
          CMD_DEL_AFTER: begin
            if (!anc_used) begin
              fin        = 1'b1;
              fin_status = ST_ANCHOR_FREE;
            end else if (!in_pool(nx_q)) begin
              fin        = 1'b1;
              fin_status = ST_NO_NEXT;
            end else begin
              link_req.raddr = nx_q[SLOT_W-1:0];
              ns_nxt         = nx_q;
              state_nxt      = S_LOOK2;
            end
          end
          CMD_CLEAR: begin
            fin       = 1'b1;
            free_nxt  = '1;
            head_nxt  = NONE_SLOT;
            tail_nxt  = NONE_SLOT;
            count_nxt = '0;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_LOOK2: begin
        do_unlink = 1'b1;
        uv        = ns_r;
        up        = anc_link;
        un        = nx_q;
      end

      S_FIX: begin
        if (in_pool(na_r)) begin
          link_req.nx_we    = 1'b1;
          link_req.nx_waddr = na_r[SLOT_W-1:0];
          link_req.nx_wdata = ns_r;
        end else begin
          head_nxt = ns_r;
        end
        if (in_pool(nn_r)) begin
          link_req.pv_we    = 1'b1;
          link_req.pv_waddr = nn_r[SLOT_W-1:0];
          link_req.pv_wdata = ns_r;
        end else begin
          tail_nxt = ns_r;
        end
        free_nxt[ns_r[SLOT_W-1:0]] = 1'b0;
        count_nxt = count_r + LINK_W'(1);
        fin       = 1'b1;
        fin_slot  = ns_r;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_unlink) begin
      if (in_pool(up)) begin
        link_req.nx_we    = 1'b1;
        link_req.nx_waddr = up[SLOT_W-1:0];
        link_req.nx_wdata = un;
      end else begin
        head_nxt = un;
      end
      if (in_pool(un)) begin
        link_req.pv_we    = 1'b1;
        link_req.pv_waddr = un[SLOT_W-1:0];
        link_req.pv_wdata = up;
      end else begin
        tail_nxt = up;
      end
      free_nxt[uv[SLOT_W-1:0]] = 1'b1;
      count_nxt = count_r - LINK_W'(1);
      fin       = 1'b1;
      fin_slot  = uv;
    end

    if (fin) begin
      state_nxt = S_IDLE;
    end
    out_valid_nxt     = fin;
    out_nxt.status    = fin_status;
    out_nxt.slot      = fin_slot;
    out_nxt.count     = count_nxt;
    out_nxt.head_slot = head_nxt;
    out_nxt.tail_slot = tail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= '1;
      head_r      <= NONE_SLOT;
      tail_r      <= NONE_SLOT;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    pay_r <= pay_nxt;
    anc_r <= anc_nxt;
    ns_r  <= ns_nxt;
    na_r  <= na_nxt;
    nn_r  <= nn_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[ent_addr] <= pay_r;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/array_doubly_linked_list.sv
// top level of the array doubly linked list: sequencer plus next and prev link rams
// depends on adl_pkg, adl_ram, adl_ctrl
`default_nettype none

// usage
//   input channel: drive in_item and raise start; the item is taken at a clock edge
//   where start is high and busy is low. busy stays high while the item is worked on.
//   result channel: out_valid is high for exactly one cycle with out_item holding
//   status, slot, count, head_slot and tail_slot; the receiver must take it then.
//   sequence: the result is registered from the look state for clear, delete front,
//   delete back and rejected commands, from the fix state after look for inserts
//   and from the look2 state after look for delete after. a new item can be taken
//   at the edge that ends the result cycle. the extra state comes from the single
//   write port of each link ram (an insert writes the new node, then its neighbors)
//   and from the dependent second link read of delete after.
//   reset: synchronous, active low; all slots free, list empty, count zero, no
//   result pending. the link rams need no clearing since only links of used slots
//   are ever used.
//   the receiver cannot stall the block.
module array_doubly_linked_list (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire adl_pkg::adl_in_t in_item,
  output logic                  busy,
  output logic                  out_valid,
  output adl_pkg::adl_out_t     out_item
);

  import adl_pkg::*;

  link_req_t         link_req;
  logic [LINK_W-1:0] nx_q;
  logic [LINK_W-1:0] pv_q;

  adl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .link_req  (link_req),
    .nx_q      (nx_q),
    .pv_q      (pv_q)
  );

  adl_ram #(
    .DEPTH (SLOTS),
    .WIDTH (LINK_W)
  ) u_next_ram (
    .clk   (clk),
    .we    (link_req.nx_we),
    .waddr (link_req.nx_waddr),
    .wdata (link_req.nx_wdata),
    .raddr (link_req.raddr),
    .rdata (nx_q)
  );

  adl_ram #(
    .DEPTH (SLOTS),
    .WIDTH (LINK_W)
  ) u_prev_ram (
    .clk   (clk),
    .we    (link_req.pv_we),
    .waddr (link_req.pv_waddr),
    .wdata (link_req.pv_wdata),
    .raddr (link_req.raddr),
    .rdata (pv_q)
  );

endmodule

`default_nettype wire

>>> hw/rtl/adl_chk.sv
// port level checks for the array doubly linked list, bound to the top level
// depends on adl_pkg
`default_nettype none

module adl_chk (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire adl_pkg::adl_out_t out_item
);

  import adl_pkg::*;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.count <= NONE_SLOT)
    else $error("count above pool size");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.count == '0) == (out_item.head_slot == NONE_SLOT)) &&
                  ((out_item.count == '0) == (out_item.tail_slot == NONE_SLOT)))
    else $error("head or tail disagrees with count");

  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.slot == NONE_SLOT)
    else $error("failed command reports a slot");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted item did not make block busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && !$past(out_valid))
    else $error("result while busy or repeated");

endmodule

bind array_doubly_linked_list adl_chk u_chk (.*);

`default_nettype wire
